>>> hw/rtl/ttds_pkg.sv
// Shared types, constants and helpers of the texture tile dimension solver.
// Self-contained; used by texture_tile_dimension_solver_top.
`default_nettype none

package ttds_pkg;

    // texel size codes
    localparam logic [1:0] PSZ_4B  = 2'd0;
    localparam logic [1:0] PSZ_8B  = 2'd1;
    localparam logic [1:0] PSZ_16B = 2'd2;
    localparam logic [1:0] PSZ_32B = 2'd3;

    // texel format codes
    localparam logic [2:0] FMT_RGBA = 3'd0;
    localparam logic [2:0] FMT_YUV  = 3'd1;
    localparam logic [2:0] FMT_CI   = 3'd2;
    localparam logic [2:0] FMT_IA   = 3'd3;
    localparam logic [2:0] FMT_I    = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_LOAD_WIDTH   = 2'd0;
    localparam logic [1:0] REG_LOAD_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_LOAD_IS_TILE = 2'd2;

    // wrap flag bits
    localparam int WF_CLAMP_S  = 0;
    localparam int WF_CLAMP_T  = 1;
    localparam int WF_MIRROR_S = 2;
    localparam int WF_MIRROR_T = 3;

    localparam int NUM_STG   = 7;
    localparam int IN_BITS   = 72;
    localparam int OUT_BITS  = 104;

    localparam logic [13:0] TEXELS_8K = 14'd8192;
    localparam logic [13:0] TEXELS_4K = 14'd4096;
    localparam logic [13:0] TEXELS_2K = 14'd2048;
    localparam logic [13:0] TEXELS_1K = 14'd1024;

    typedef struct packed {
        logic [13:0] budget;
        logic [2:0]  shift;
    } tex_entry_t;

    typedef struct packed {
        logic [13:0] rem;
        logic [3:0]  q;
    } div_res_t;

    // per-stage descriptor context; fields fill in as the item moves down
    typedef struct packed {
        logic [13:0] budget;
        logic [15:0] tile_w;
        logic [15:0] tile_h;
        logic [3:0]  ms;
        logic [3:0]  mt;
        logic [12:0] line_w;
        logic [3:0]  wf;
        logic        mask_ok;
        logic        tile_ok;
        logic [31:0] prod;
        logic [13:0] rem;
        logic [15:0] quo;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] cw;
        logic [15:0] ch;
        logic [16:0] rw;
        logic [16:0] rh;
    } ctx_t;

    function automatic tex_entry_t tex_lookup(input logic [1:0] sz, input logic [2:0] fmt);
        tex_entry_t e;
        e.budget = '0;
        e.shift  = '0;
        unique case (sz)
            PSZ_4B: begin
                case (fmt)
                    FMT_RGBA, FMT_CI: begin e.budget = TEXELS_4K; e.shift = 3'd4; end
                    FMT_IA, FMT_I:    begin e.budget = TEXELS_8K; e.shift = 3'd4; end
                    default: ;
                endcase
            end
            PSZ_8B: begin
                case (fmt)
                    FMT_CI:        begin e.budget = TEXELS_2K; e.shift = 3'd3; end
                    FMT_IA, FMT_I: begin e.budget = TEXELS_4K; e.shift = 3'd3; end
                    default: ;
                endcase
            end
            PSZ_16B: begin
                case (fmt)
                    FMT_RGBA, FMT_YUV, FMT_IA: begin e.budget = TEXELS_2K; e.shift = 3'd2; end
                    default: ;
                endcase
            end
            PSZ_32B: begin
                if (fmt == FMT_RGBA) begin
                    e.budget = TEXELS_1K;
                    e.shift  = 3'd2;
                end
            end
            default: ;
        endcase
        return e;
    endfunction

    // four restoring-division steps; rem stays below a nonzero divisor
    function automatic div_res_t div_step4(input logic [13:0] rem, input logic [3:0] bits,
                                           input logic [12:0] dvs);
        div_res_t res;
        logic [13:0] r;
        r = rem;
        res.q = '0;
        for (int i = 3; i >= 0; i--) begin
            r = {r[12:0], bits[i]};
            if (r >= {1'b0, dvs}) begin
                r = r - {1'b0, dvs};
                res.q[i] = 1'b1;
            end
        end
        res.rem = r;
        return res;
    endfunction

    // smallest power of two not below v, at least 1
    function automatic logic [16:0] round_pow2(input logic [15:0] v);
        logic [16:0] x;
        x = {1'b0, v} - 17'd1;
        x = x | (x >> 1);
        x = x | (x >> 2);
        x = x | (x >> 4);
        x = x | (x >> 8);
        if (v == 16'd0)
            return 17'd1;
        return x + 17'd1;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/texture_tile_dimension_solver_top.sv
// Texture tile dimension solver: seven-stage pipeline from tile descriptor to sizes.
// Depends on ttds_pkg (table lookup, division step, power-of-two rounding).
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata: tile descriptor, 72 bits
//  m_       | out | m_tvalid/m_tready  | m_tdata: sizes, 104 bits
//  cfg_     | in  | cfg_wr_en          | cfg_addr, cfg_wdata: load tile registers
//
// One beat in per cycle while m_tready does not hold the pipeline full; stage 1..4
// each run four bits of the line-height division, stage 1 also holds the 16x16
// tile-area multiplier. Each stage loads when it is empty or its contents move on, so
// bubbles close up and a beat is taken while a result waits at m_ if a stage is empty.
// aresetn (synchronous) clears the stage valid bits and the load registers.
`default_nettype none

module texture_tile_dimension_solver_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pixel_size[1:0] format[4:2] ul_s[14:5] lr_s[24:15] ul_t[34:25] lr_t[44:35]
    // mask_s[48:45] mask_t[52:49] wrap_flags[56:53] line_words[65:57], rest zero
    input  wire logic [ttds_pkg::IN_BITS-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // width[15:0] height[31:16] clamp_width[47:32] clamp_height[63:48]
    // real_width[80:64] real_height[97:81], rest zero
    output logic [ttds_pkg::OUT_BITS-1:0]      m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [15:0]                   cfg_wdata
);

    localparam int LAST = ttds_pkg::NUM_STG - 1;

    logic [15:0] load_width_reg;
    logic [15:0] load_height_reg;
    logic        load_is_tile_reg;

    logic [ttds_pkg::NUM_STG-1:0] vld_reg;
    logic [ttds_pkg::NUM_STG-1:0] vld_next;
    logic [ttds_pkg::NUM_STG-1:0] rdy;
    ttds_pkg::ctx_t pipe_reg  [ttds_pkg::NUM_STG];
    ttds_pkg::ctx_t pipe_next [ttds_pkg::NUM_STG];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_width_reg   <= '0;
            load_height_reg  <= '0;
            load_is_tile_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ttds_pkg::REG_LOAD_WIDTH:   load_width_reg   <= cfg_wdata;
                ttds_pkg::REG_LOAD_HEIGHT:  load_height_reg  <= cfg_wdata;
                ttds_pkg::REG_LOAD_IS_TILE: load_is_tile_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ready ripples back from the output
    always_comb begin
        rdy[LAST] = !vld_reg[LAST] || m_tready;
        for (int k = LAST - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    assign s_tready = rdy[0];

    always_comb begin
        vld_next[0] = s_tvalid;
        for (int k = 1; k < ttds_pkg::NUM_STG; k++)
            vld_next[k] = vld_reg[k-1];
    end

    // stage 0: decode, table, tile sizes, mask area test
    always_comb begin
        ttds_pkg::tex_entry_t te;
        logic [1:0]  sz;
        logic [2:0]  fmt;
        logic [4:0]  msum;
        logic [30:0] marea;
        sz  = s_tdata[1:0];
        fmt = s_tdata[4:2];
        te  = ttds_pkg::tex_lookup(sz, fmt);
        pipe_next[0]        = '0;
        pipe_next[0].budget = te.budget;
        pipe_next[0].tile_w = {6'd0, s_tdata[24:15]} - {6'd0, s_tdata[14:5]} + 16'd1;
        pipe_next[0].tile_h = {6'd0, s_tdata[44:35]} - {6'd0, s_tdata[34:25]} + 16'd1;
        pipe_next[0].ms     = s_tdata[48:45];
        pipe_next[0].mt     = s_tdata[52:49];
        pipe_next[0].wf     = s_tdata[56:53];
        pipe_next[0].line_w = {4'd0, s_tdata[65:57]} << te.shift;
        msum  = {1'b0, s_tdata[48:45]} + {1'b0, s_tdata[52:49]};
        marea = 31'd1 << msum;
        pipe_next[0].mask_ok = marea <= {17'd0, te.budget};
    end

    // stages 1..4: division budget / line_w, four quotient bits each; tile area in stage 1, area test in stage 2
    always_comb begin
        ttds_pkg::div_res_t dr1;
        ttds_pkg::div_res_t dr2;
        ttds_pkg::div_res_t dr3;
        ttds_pkg::div_res_t dr4;
        logic [15:0] dvd1;
        logic [15:0] dvd2;
        logic [15:0] dvd3;
        logic [15:0] dvd4;

        pipe_next[1]      = pipe_reg[0];
        pipe_next[1].prod = 32'(pipe_reg[0].tile_w) * 32'(pipe_reg[0].tile_h);
        dvd1 = {2'b00, pipe_reg[0].budget};
        dr1  = ttds_pkg::div_step4(14'd0, dvd1[15:12], pipe_reg[0].line_w);
        pipe_next[1].rem = dr1.rem;
        pipe_next[1].quo = {12'd0, dr1.q};

        pipe_next[2]         = pipe_reg[1];
        pipe_next[2].tile_ok = pipe_reg[1].prod <= {18'd0, pipe_reg[1].budget};
        dvd2 = {2'b00, pipe_reg[1].budget};
        dr2  = ttds_pkg::div_step4(pipe_reg[1].rem, dvd2[11:8], pipe_reg[1].line_w);
        pipe_next[2].rem = dr2.rem;
        pipe_next[2].quo = {pipe_reg[1].quo[11:0], dr2.q};

        pipe_next[3] = pipe_reg[2];
        dvd3 = {2'b00, pipe_reg[2].budget};
        dr3  = ttds_pkg::div_step4(pipe_reg[2].rem, dvd3[7:4], pipe_reg[2].line_w);
        pipe_next[3].rem = dr3.rem;
        pipe_next[3].quo = {pipe_reg[2].quo[11:0], dr3.q};

        pipe_next[4] = pipe_reg[3];
        dvd4 = {2'b00, pipe_reg[3].budget};
        dr4  = ttds_pkg::div_step4(pipe_reg[3].rem, dvd4[3:0], pipe_reg[3].line_w);
        pipe_next[4].rem = dr4.rem;
        pipe_next[4].quo = {pipe_reg[3].quo[11:0], dr4.q};
    end

    // stage 5: line height, priority choice of width / height, and clamp sizes
    always_comb begin
        logic [15:0] mask_w;
        logic [15:0] mask_h;
        logic [15:0] line_h;
        logic [15:0] lmin;
        ttds_pkg::ctx_t c;
        c      = pipe_reg[4];
        mask_w = 16'd1 << c.ms;
        mask_h = 16'd1 << c.mt;
        lmin   = (c.quo < c.tile_h) ? c.quo : c.tile_h;
        lmin   = (lmin < mask_h) ? lmin : mask_h;
        line_h = (c.line_w == 13'd0) ? 16'd0 : lmin;

        pipe_next[5] = c;
        if (c.ms != 4'd0 && c.mask_ok)
            pipe_next[5].w = mask_w;
        else if (c.tile_ok)
            pipe_next[5].w = c.tile_w;
        else if (load_is_tile_reg)
            pipe_next[5].w = load_width_reg;
        else
            pipe_next[5].w = {3'd0, c.line_w};

        if (c.mt != 4'd0 && c.mask_ok)
            pipe_next[5].h = mask_h;
        else if (c.tile_ok)
            pipe_next[5].h = c.tile_h;
        else if (load_is_tile_reg)
            pipe_next[5].h = load_height_reg;
        else
            pipe_next[5].h = line_h;

        pipe_next[5].cw = c.wf[ttds_pkg::WF_CLAMP_S] ? c.tile_w : pipe_next[5].w;
        pipe_next[5].ch = c.wf[ttds_pkg::WF_CLAMP_T] ? c.tile_h : pipe_next[5].h;
    end

    // stage 6: buffer sizes
    always_comb begin
        logic [15:0] mask_w;
        logic [15:0] mask_h;
        ttds_pkg::ctx_t c;
        c      = pipe_reg[5];
        mask_w = 16'd1 << c.ms;
        mask_h = 16'd1 << c.mt;
        pipe_next[6] = c;
        if (c.wf[ttds_pkg::WF_CLAMP_S])
            pipe_next[6].rw = ttds_pkg::round_pow2(c.cw);
        else if (c.wf[ttds_pkg::WF_MIRROR_S])
            pipe_next[6].rw = {mask_w, 1'b0};
        else
            pipe_next[6].rw = ttds_pkg::round_pow2(c.w);

        if (c.wf[ttds_pkg::WF_CLAMP_T])
            pipe_next[6].rh = ttds_pkg::round_pow2(c.ch);
        else if (c.wf[ttds_pkg::WF_MIRROR_T])
            pipe_next[6].rh = {mask_h, 1'b0};
        else
            pipe_next[6].rh = ttds_pkg::round_pow2(c.h);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < ttds_pkg::NUM_STG; k++)
                if (rdy[k])
                    vld_reg[k] <= vld_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ttds_pkg::NUM_STG; k++)
            if (rdy[k])
                pipe_reg[k] <= pipe_next[k];
    end

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = {6'd0, pipe_reg[LAST].rh, pipe_reg[LAST].rw,
                       pipe_reg[LAST].ch, pipe_reg[LAST].cw,
                       pipe_reg[LAST].h, pipe_reg[LAST].w};

    // an empty output stage always frees the input
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[LAST] |-> s_tready)
        else $error("input stalled with empty output stage");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted beat missing from stage 0");

    a_real_w_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[80:64]))
        else $error("real_width not a power of two");

    a_real_h_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[97:81]))
        else $error("real_height not a power of two");

endmodule

`default_nettype wire
